// ===== design/rmqf_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the error probability table for the read quality filter.
package rmqf_pkg;

  localparam int unsigned MaxReadLenDefault   = 65536;
  localparam int unsigned ProbFracBitsDefault = 32;

  localparam int unsigned QualW    = 8;
  localparam int unsigned ReadLenW = 17;
  localparam int unsigned CountW   = 32;
  localparam int unsigned SumW     = 49;
  localparam int unsigned MmqW     = 8;
  localparam int unsigned ScoreW   = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 17;

  localparam int unsigned PhredOffset = 33;
  localparam int unsigned PhredMax    = 93;

  localparam logic [CfgIdxW-1:0] RegMinReadLength  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegMinMeanQuality = CfgIdxW'(1);

  localparam logic [63:0] DecOne = 64'd1000000000000000000;

  typedef logic [PhredMax:0][63:0] prob_tab_t;

  typedef enum logic [1:0] {
    QmPass,
    QmFail,
    QmCmp
  } qmode_e;

  // 10^(-b/10) scaled by 10^18
  function automatic logic [63:0] tenth_pow_dec(input int unsigned b);
    logic [63:0] v;
    case (b)
      0:       v = 64'd1000000000000000000;
      1:       v = 64'd794328234724281502;
      2:       v = 64'd630957344480193249;
      3:       v = 64'd501187233627272285;
      4:       v = 64'd398107170553497250;
      5:       v = 64'd316227766016837933;
      6:       v = 64'd251188643150957910;
      7:       v = 64'd199526231496887960;
      8:       v = 64'd158489319246111348;
      9:       v = 64'd125892541179416721;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] prob_entry(input int unsigned q, input int unsigned frac_bits);
    logic [63:0]  d;
    logic [63:0]  m;
    logic [63:0]  r;
    int unsigned  a;
    int unsigned  b;
    a = q / 10;
    b = q % 10;
    d = tenth_pow_dec(b);
    m = (d >= DecOne) ? 64'd1 : 64'd0;
    r = (d >= DecOne) ? d - DecOne : d;
    for (int i = 0; i < 62; i++) begin
      r = r << 1;
      m = m << 1;
      if (r >= DecOne) begin
        r    = r - DecOne;
        m[0] = 1'b1;
      end
    end
    for (int i = 0; i < 10; i++) begin
      if (i < a) begin
        m = m / 64'd10;
      end
    end
    return (m + (64'd1 << (61 - frac_bits))) >> (62 - frac_bits);
  endfunction

  function automatic prob_tab_t build_tab(input int unsigned frac_bits);
    prob_tab_t t;
    for (int q = 0; q <= PhredMax; q++) begin
      t[q] = prob_entry(q, frac_bits);
    end
    return t;
  endfunction

  function automatic logic [ScoreW-1:0] score_of(input logic [QualW-1:0] qc);
    logic [ScoreW-1:0] s;
    if (qc < QualW'(PhredOffset)) begin
      s = '0;
    end else if (qc > QualW'(PhredOffset + PhredMax)) begin
      s = ScoreW'(PhredMax);
    end else begin
      s = ScoreW'(qc - QualW'(PhredOffset));
    end
    return s;
  endfunction

endpackage

// ===== design/rmqf_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: quality items in, config writes, read results out.
interface rmqf_in_if;
  logic                       valid;
  logic                       ready;
  logic [rmqf_pkg::QualW-1:0] quality_char;
  logic                       last_in_read;

  modport source (output valid, quality_char, last_in_read, input ready);
  modport sink   (input valid, quality_char, last_in_read, output ready);
  modport mon    (input valid, quality_char, last_in_read, ready);
endinterface

interface rmqf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rmqf_pkg::CfgIdxW-1:0]  index;
  logic [rmqf_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, index, data, ready);
endinterface

interface rmqf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          keep_read;
  logic [rmqf_pkg::ReadLenW-1:0] read_length;
  logic [rmqf_pkg::CountW-1:0]   reads_seen;
  logic [rmqf_pkg::CountW-1:0]   reads_kept;

  modport source (output valid, keep_read, read_length, reads_seen, reads_kept, input ready);
  modport sink   (input valid, keep_read, read_length, reads_seen, reads_kept, output ready);
  modport mon    (input valid, keep_read, read_length, reads_seen, reads_kept, ready);
endinterface

// ===== design/rmqf_front.sv =====
`timescale 1ns / 1ps
// Front end: per-character score, probability lookup, running sum and length count.
module rmqf_front #(
  parameter int unsigned MAX_READ_LEN   = rmqf_pkg::MaxReadLenDefault,
  parameter int unsigned PROB_FRAC_BITS = rmqf_pkg::ProbFracBitsDefault,
  localparam int unsigned LenW          = $clog2(MAX_READ_LEN + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rmqf_in_if.sink                   in_i,
  output logic                      push_valid_o,
  input  logic                      push_ready_i,
  output logic [rmqf_pkg::SumW-1:0] push_sum_o,
  output logic [LenW-1:0]           push_len_o
);

  localparam int unsigned EntW = PROB_FRAC_BITS + 1;
  localparam int unsigned SumW = rmqf_pkg::SumW;
  localparam rmqf_pkg::prob_tab_t ProbTab = rmqf_pkg::build_tab(PROB_FRAC_BITS);

  logic [SumW-1:0]            sum_q, sum_d;
  logic [LenW-1:0]            len_q, len_d;
  logic [rmqf_pkg::ScoreW-1:0] score;
  logic [EntW-1:0]            ent;
  logic [SumW:0]              sum_add;
  logic [SumW-1:0]            sum_sat;
  logic                       counting;
  logic                       acc;

  assign in_i.ready   = push_ready_i;
  assign acc          = in_i.valid && in_i.ready;
  assign push_valid_o = in_i.valid && in_i.last_in_read;

  always_comb begin
    score    = rmqf_pkg::score_of(in_i.quality_char);
    ent      = ProbTab[score][EntW-1:0];
    sum_add  = {1'b0, sum_q} + {{(SumW + 1 - EntW){1'b0}}, ent};
    sum_sat  = sum_add[SumW] ? {SumW{1'b1}} : sum_add[SumW-1:0];
    counting = len_q < LenW'(MAX_READ_LEN);
    sum_d    = counting ? sum_sat : sum_q;
    len_d    = counting ? len_q + LenW'(1) : len_q;
  end

  assign push_sum_o = sum_d;
  assign push_len_o = len_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      len_q <= '0;
    end else if (acc) begin
      if (in_i.last_in_read) begin
        sum_q <= '0;
        len_q <= '0;
      end else begin
        sum_q <= sum_d;
        len_q <= len_d;
      end
    end
  end

endmodule

// ===== design/rmqf_fifo.sv =====
`timescale 1ns / 1ps
// Small register queue of finished read records between front and back.
module rmqf_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== design/rmqf_back.sv =====
`timescale 1ns / 1ps
// Back end: threshold multiply, keep decision, read counters and result register.
module rmqf_back #(
  parameter int unsigned MAX_READ_LEN   = rmqf_pkg::MaxReadLenDefault,
  parameter int unsigned PROB_FRAC_BITS = rmqf_pkg::ProbFracBitsDefault,
  localparam int unsigned LenW          = $clog2(MAX_READ_LEN + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  logic [rmqf_pkg::SumW-1:0]     pop_sum_i,
  input  logic [LenW-1:0]               pop_len_i,
  input  logic [rmqf_pkg::ReadLenW-1:0] min_read_length_i,
  input  logic [rmqf_pkg::MmqW-1:0]     min_mean_quality_i,
  rmqf_out_if.source                    out_o
);

  localparam int unsigned SumW  = rmqf_pkg::SumW;
  localparam int unsigned EntW  = PROB_FRAC_BITS + 1;
  localparam int unsigned TLoW  = EntW / 2;
  localparam int unsigned THiW  = EntW - TLoW;
  localparam int unsigned ProdW = LenW + EntW;
  localparam int unsigned CmpW  = (LenW > rmqf_pkg::ReadLenW) ? LenW : rmqf_pkg::ReadLenW;
  localparam int unsigned SCmpW = (ProdW > SumW) ? ProdW : SumW;
  localparam rmqf_pkg::prob_tab_t ProbTab = rmqf_pkg::build_tab(PROB_FRAC_BITS);

  // stage 1
  logic                   s1_valid_q;
  logic [SumW-1:0]        s1_sum_q;
  logic [LenW-1:0]        s1_len_q;
  logic [LenW+TLoW-1:0]   s1_plo_q, s1_plo_d;
  logic [LenW+THiW-1:0]   s1_phi_q, s1_phi_d;
  logic                   s1_len_ok_q, s1_len_ok_d;
  rmqf_pkg::qmode_e       s1_qmode_q, s1_qmode_d;
  logic [rmqf_pkg::ScoreW-1:0] thr_idx;
  logic [EntW-1:0]        thr;

  // result register
  logic                          out_valid_q;
  logic                          keep_q, keep_d;
  logic [rmqf_pkg::ReadLenW-1:0] rlen_q;
  logic [rmqf_pkg::CountW-1:0]   seen_q, kept_q;
  logic [ProdW-1:0]              prod;
  logic                          sum_lt;

  logic out_load, s1_load;

  assign out_load    = !out_valid_q || out_o.ready;
  assign s1_load     = !s1_valid_q || out_load;
  assign pop_ready_o = s1_load;

  always_comb begin
    if (min_mean_quality_i[rmqf_pkg::MmqW-1]) begin
      s1_qmode_d = rmqf_pkg::QmPass;
    end else if (min_mean_quality_i > rmqf_pkg::MmqW'(rmqf_pkg::PhredMax)) begin
      s1_qmode_d = rmqf_pkg::QmFail;
    end else begin
      s1_qmode_d = rmqf_pkg::QmCmp;
    end
    thr_idx = (s1_qmode_d == rmqf_pkg::QmCmp) ?
              min_mean_quality_i[rmqf_pkg::ScoreW-1:0] : '0;
    thr         = ProbTab[thr_idx][EntW-1:0];
    s1_plo_d    = (LenW + TLoW)'(pop_len_i) * (LenW + TLoW)'(thr[TLoW-1:0]);
    s1_phi_d    = (LenW + THiW)'(pop_len_i) * (LenW + THiW)'(thr[EntW-1:TLoW]);
    s1_len_ok_d = CmpW'(pop_len_i) >= CmpW'(min_read_length_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && pop_valid_i) begin
      s1_sum_q    <= pop_sum_i;
      s1_len_q    <= pop_len_i;
      s1_plo_q    <= s1_plo_d;
      s1_phi_q    <= s1_phi_d;
      s1_len_ok_q <= s1_len_ok_d;
      s1_qmode_q  <= s1_qmode_d;
    end
  end

  always_comb begin
    prod   = (ProdW'(s1_phi_q) << TLoW) + ProdW'(s1_plo_q);
    sum_lt = SCmpW'(s1_sum_q) < SCmpW'(prod);
    case (s1_qmode_q)
      rmqf_pkg::QmPass: keep_d = s1_len_ok_q;
      rmqf_pkg::QmCmp:  keep_d = s1_len_ok_q && sum_lt;
      default:          keep_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      seen_q      <= '0;
      kept_q      <= '0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        seen_q <= seen_q + rmqf_pkg::CountW'(1);
        kept_q <= kept_q + rmqf_pkg::CountW'(keep_d);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      keep_q <= keep_d;
      rlen_q <= rmqf_pkg::ReadLenW'(s1_len_q);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.keep_read   = keep_q;
  assign out_o.read_length = rlen_q;
  assign out_o.reads_seen  = seen_q;
  assign out_o.reads_kept  = kept_q;

endmodule

// ===== design/read_mean_quality_filter_top.sv =====
`timescale 1ns / 1ps
// Read mean-quality filter: takes one quality character per cycle with no bubbles and
// emits one keep/drop result per read; when the last character of a read is accepted,
// its sum and length close into the record queue, then pass a threshold multiply stage
// and then the result register, where the result is valid. Input stalls only when
// the four-entry record queue between the accumulator and the decision stages is full,
// i.e. when results are held back by the output and reads keep finishing.
module read_mean_quality_filter_top #(
  parameter int unsigned MAX_READ_LEN   = rmqf_pkg::MaxReadLenDefault,
  parameter int unsigned PROB_FRAC_BITS = rmqf_pkg::ProbFracBitsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rmqf_in_if.sink  in_i,
  rmqf_cfg_if.sink cfg_i,
  rmqf_out_if.source out_o
);

  localparam int unsigned LenW   = $clog2(MAX_READ_LEN + 1);
  localparam int unsigned SumW   = rmqf_pkg::SumW;
  localparam int unsigned RecW   = SumW + LenW;
  localparam int unsigned QDepth = 4;

  logic [rmqf_pkg::ReadLenW-1:0] min_len_q;
  logic [rmqf_pkg::MmqW-1:0]     mmq_q;

  logic            push_valid, push_ready;
  logic [SumW-1:0] push_sum;
  logic [LenW-1:0] push_len;
  logic            pop_valid, pop_ready;
  logic [RecW-1:0] pop_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= '0;
      mmq_q     <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rmqf_pkg::RegMinReadLength:  min_len_q <= cfg_i.data[rmqf_pkg::ReadLenW-1:0];
        rmqf_pkg::RegMinMeanQuality: mmq_q     <= cfg_i.data[rmqf_pkg::MmqW-1:0];
        default: ;
      endcase
    end
  end

  rmqf_front #(
    .MAX_READ_LEN  (MAX_READ_LEN),
    .PROB_FRAC_BITS(PROB_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_sum_o  (push_sum),
    .push_len_o  (push_len)
  );

  rmqf_fifo #(
    .Width(RecW),
    .Depth(QDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i ({push_sum, push_len}),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  rmqf_back #(
    .MAX_READ_LEN  (MAX_READ_LEN),
    .PROB_FRAC_BITS(PROB_FRAC_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pop_valid_i       (pop_valid),
    .pop_ready_o       (pop_ready),
    .pop_sum_i         (pop_data[RecW-1:LenW]),
    .pop_len_i         (pop_data[LenW-1:0]),
    .min_read_length_i (min_len_q),
    .min_mean_quality_i(mmq_q),
    .out_o             (out_o)
  );

endmodule

// ===== design/rmqf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the read quality filter, bound to the top level.
module rmqf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        in_last_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        out_keep_i,
  input logic [rmqf_pkg::CountW-1:0] out_seen_i,
  input logic [rmqf_pkg::CountW-1:0] out_kept_i
);

  logic                        have_q;
  logic                        any_last_q;
  logic [rmqf_pkg::CountW-1:0] seen_q, kept_q;
  logic                        out_acc;

  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q     <= 1'b0;
      any_last_q <= 1'b0;
      seen_q     <= '0;
      kept_q     <= '0;
    end else begin
      if (in_valid_i && in_ready_i && in_last_i) begin
        any_last_q <= 1'b1;
      end
      if (out_acc) begin
        have_q <= 1'b1;
        seen_q <= out_seen_i;
        kept_q <= out_kept_i;
      end
    end
  end

  a_seen_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> out_seen_i == (have_q ? seen_q + rmqf_pkg::CountW'(1)
                                      : rmqf_pkg::CountW'(1)))
    else $error("reads_seen did not advance by one");

  a_kept_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> out_kept_i == (have_q ? kept_q : '0)
                              + rmqf_pkg::CountW'(out_keep_i))
    else $error("reads_kept does not follow keep_read");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> any_last_q)
    else $error("result without any finished read");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_seen_i)
                                    && $stable(out_keep_i))
    else $error("stalled result changed");

endmodule

bind read_mean_quality_filter_top rmqf_checker u_rmqf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_last_i  (in_i.last_in_read),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_keep_i (out_o.keep_read),
  .out_seen_i (out_o.reads_seen),
  .out_kept_i (out_o.reads_kept)
);

// ===== test/tb_read_mean_quality_filter_top.sv =====
`timescale 1ns / 1ps
// Testbench for the read mean-quality filter: directed and random reads, checked against a predictor.
module tb_read_mean_quality_filter_top;
  import rmqf_pkg::*;

  localparam int unsigned MaxLen        = MaxReadLenDefault;
  localparam int unsigned FracBits      = ProbFracBitsDefault;
  localparam int unsigned WideW         = SumW + 1;
  localparam int unsigned QPadW         = CfgDataW - MmqW;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned RandomItems   = 1450;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned IdlePct       = 24;
  localparam int unsigned MaxReports    = 10;

  localparam logic [SumW-1:0]    SumSat    = '1;
  localparam logic [CfgIdxW-1:0] RegSpareA = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSpareB = CfgIdxW'(3);

  localparam logic [MmqW-1:0] QualAll     = 8'hFF;
  localparam logic [MmqW-1:0] QualMostNeg = 8'h80;
  localparam logic [MmqW-1:0] QualTop     = 8'd93;
  localparam logic [MmqW-1:0] QualMaxPos  = 8'd127;

  // 10^(-b/10) * 10^18 for b = 9 down to 0
  localparam logic [9:0][63:0] TenthPow = {
    64'd125892541179416721, 64'd158489319246111348, 64'd199526231496887960,
    64'd251188643150957910, 64'd316227766016837933, 64'd398107170553497250,
    64'd501187233627272285, 64'd630957344480193249, 64'd794328234724281502,
    64'd1000000000000000000
  };
  localparam logic [127:0] DecScale = 128'd1000000000000000000;

  typedef struct packed {
    logic                keep;
    logic [ReadLenW-1:0] len;
    logic [CountW-1:0]   seen;
    logic [CountW-1:0]   kept;
  } read_verdict_t;

  class read_filter_scoreboard;
    logic [63:0]            err_prob [PhredMax+1];
    logic [ReadLenW-1:0]    min_len;
    logic signed [MmqW-1:0] min_q;
    logic [SumW-1:0]        prob_sum;
    logic [ReadLenW-1:0]    len_cnt;
    logic [CountW-1:0]      seen_cnt;
    logic [CountW-1:0]      kept_cnt;
    read_verdict_t          verdict_q[$];
    int unsigned            mismatches;
    int unsigned            chars_seen;
    int unsigned            reads_done;
    int unsigned            reads_kept;

    function new();
      logic [127:0] scaled;
      logic [127:0] p10;
      for (int q = 0; q <= PhredMax; q++) begin
        p10 = 128'd1;
        for (int k = 0; k < q / 10; k++) p10 = p10 * 128'd10;
        scaled = ((128'(TenthPow[q % 10]) << 62) / DecScale) / p10;
        err_prob[q] = 64'((scaled + (128'd1 << (61 - FracBits))) >> (62 - FracBits));
      end
      min_len    = '0;
      min_q      = '0;
      prob_sum   = '0;
      len_cnt    = '0;
      seen_cnt   = '0;
      kept_cnt   = '0;
      mismatches = 0;
      chars_seen = 0;
      reads_done = 0;
      reads_kept = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == RegMinReadLength) begin
        min_len = data[ReadLenW-1:0];
      end else if (idx == RegMinMeanQuality) begin
        min_q = data[MmqW-1:0];
      end
    endfunction

    // mean quality above min_q, tested as sum < len * p(min_q)
    function logic quality_ok();
      logic [63:0] thr;
      if (min_q < 0) return 1'b1;
      if (int'(min_q) > int'(PhredMax)) return 1'b0;
      thr = err_prob[int'(min_q)];
      if (thr == 64'd0) return 1'b0;
      if (64'(len_cnt) > 64'(SumSat) / thr) return 1'b1;
      return 64'(prob_sum) < 64'(len_cnt) * thr;
    endfunction

    function void note_char(logic [QualW-1:0] qc, logic last);
      int unsigned   score;
      logic [WideW-1:0] wide;
      read_verdict_t v;
      chars_seen++;
      score = (qc < PhredOffset) ? 0 : qc - PhredOffset;
      if (score > PhredMax) score = PhredMax;
      if (len_cnt < MaxLen) begin
        len_cnt++;
        wide = WideW'(prob_sum) + WideW'(err_prob[score]);
        prob_sum = (wide > WideW'(SumSat)) ? SumSat : wide[SumW-1:0];
      end
      if (last) begin
        v.keep = (len_cnt >= min_len) && quality_ok();
        seen_cnt++;
        if (v.keep) kept_cnt++;
        v.len  = len_cnt;
        v.seen = seen_cnt;
        v.kept = kept_cnt;
        verdict_q.push_back(v);
        reads_done++;
        if (v.keep) reads_kept++;
        prob_sum = '0;
        len_cnt  = '0;
      end
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= MaxReports) $display("mismatch %0d at %0t: %s", mismatches, $time, what);
    endfunction

    function void check_result(read_verdict_t got);
      read_verdict_t want;
      if (verdict_q.size() == 0) begin
        flag($sformatf("result with none pending: keep=%0b len=%0d seen=%0d kept=%0d",
                       got.keep, got.len, got.seen, got.kept));
        return;
      end
      want = verdict_q.pop_front();
      if (got.keep !== want.keep || got.len !== want.len ||
          got.seen !== want.seen || got.kept !== want.kept) begin
        flag($sformatf("want keep=%0b len=%0d seen=%0d kept=%0d, got keep=%0b len=%0d seen=%0d kept=%0d",
                       want.keep, want.len, want.seen, want.kept,
                       got.keep, got.len, got.seen, got.kept));
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  bit          no_idle;
  int unsigned stall_cycles;
  int unsigned settings_used;

  read_filter_scoreboard sb = new();

  rmqf_in_if  in_if();
  rmqf_cfg_if cfg_if();
  rmqf_out_if out_if();

  read_mean_quality_filter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: check, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_result('{out_if.keep_read, out_if.read_length,
                        out_if.reads_seen, out_if.reads_kept});
    end
    out_if.ready <= no_idle || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles, %0d results pending",
                 stall_cycles, sb.pending());
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [QualW-1:0] qc, input logic last);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.quality_char <= qc;
    in_if.last_in_read <= last;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_char(qc, last);
  endtask

  // scores jitter around base; some chars are any byte at all
  task automatic send_random_read(input int unsigned n, input int unsigned base);
    logic [QualW-1:0] qc;
    int               s;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) begin
        qc = QualW'($urandom_range(255));
      end else begin
        s = int'(base) + int'($urandom_range(6)) - 3;
        if (s < 0) s = 0;
        if (s > int'(PhredMax)) s = PhredMax;
        qc = QualW'(s + int'(PhredOffset));
      end
      send_char(qc, i == n - 1);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(input logic [CfgDataW-1:0] len, input logic [MmqW-1:0] q,
                            input logic with_spare);
    drain();
    write_reg(RegMinReadLength, len);
    write_reg(RegMinMeanQuality, {QPadW'($urandom), q});
    if (with_spare) begin
      write_reg(RegSpareA, '1);
      write_reg(RegSpareB, CfgDataW'($urandom));
    end
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int unsigned phase_items;
    int unsigned n;
    logic [CfgDataW-1:0] len_sel;
    logic [MmqW-1:0]     q_sel;

    rst_ni             <= 1'b0;
    no_idle            = 1'b0;
    settings_used      = 0;
    in_if.valid        <= 1'b0;
    in_if.quality_char <= '0;
    in_if.last_in_read <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= RegMinReadLength;
    cfg_if.data        <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: length 0, quality 0
    send_char(8'h00, 1'b1);   // below offset, score 0 equals threshold: dropped
    send_char(8'hFF, 1'b1);   // above range, clamped to 93
    send_char(8'd126, 1'b0);
    send_char(8'd127, 1'b0);
    send_char(8'd32, 1'b0);
    send_char(8'd33, 1'b1);

    set_config(CfgDataW'(3), 8'd20, 1'b1);
    repeat (4) send_char(8'd53, 1'b0);
    send_char(8'd53, 1'b1);   // mean exactly at threshold
    send_char(8'd54, 1'b0);
    send_char(8'd54, 1'b0);
    send_char(8'd54, 1'b1);
    send_char(8'd73, 1'b0);
    send_char(8'd73, 1'b1);   // too short

    set_config('0, QualAll, 1'b0);
    send_char(8'd33, 1'b0);
    send_char(8'd33, 1'b0);
    send_char(8'd33, 1'b1);
    set_config('0, QualMostNeg, 1'b0);
    send_char(8'd35, 1'b1);
    set_config('0, QualTop, 1'b0);
    send_char(8'd126, 1'b1);
    set_config('0, QualMaxPos, 1'b0);
    send_char(8'd126, 1'b1);
    send_random_read(3, 40);

    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph)
        0: begin
          len_sel = '0;
          q_sel   = MmqW'($urandom_range(10, 30));
        end
        1: begin
          len_sel = CfgDataW'($urandom_range(5, 25));
          q_sel   = QualAll;
        end
        2: begin
          len_sel = CfgDataW'(MaxLen);
          q_sel   = MmqW'($urandom_range(0, 40));
        end
        3: begin
          len_sel = CfgDataW'($urandom_range(1, 40));
          q_sel   = '0;
        end
        4: begin
          len_sel = CfgDataW'($urandom_range(0, MaxLen));
          q_sel   = MmqW'($urandom_range(0, 93));
        end
        5: begin
          len_sel = CfgDataW'($urandom_range(0, 10));
          q_sel   = QualTop;
        end
        6: begin
          len_sel = CfgDataW'($urandom_range(0, 20));
          q_sel   = MmqW'($urandom_range(128, 255));
        end
        default: begin
          len_sel = CfgDataW'($urandom_range(0, 30));
          q_sel   = MmqW'($urandom_range(255));
        end
      endcase
      set_config(len_sel, q_sel, ph % 3 == 0);
      no_idle = (ph == 3);
      phase_items = 0;
      while (phase_items < RandomItems / RandomPhases) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(31, 200) : $urandom_range(1, 30);
        if (n > RandomItems / RandomPhases - phase_items) begin
          n = RandomItems / RandomPhases - phase_items;
        end
        send_random_read(n, $urandom_range(0, 45));
        phase_items += n;
      end
    end
    no_idle = 1'b0;

    drain();
    $display("ran %0d quality chars in %0d reads, %0d kept, over %0d filter settings",
             sb.chars_seen, sb.reads_done, sb.reads_kept, settings_used);
    $display("%0d mismatching results", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
